[design/smdf_pkg.sv]
// ----------------------------------------------------------------------------
// smdf_pkg
// Shared types and constants of the SPI master with FIFOs and a descriptor.
// ----------------------------------------------------------------------------
package smdf_pkg;

    localparam int SEND_DEPTH_DEF  = 32;
    localparam int RECV_DEPTH_DEF  = 32;
    localparam int NUM_SELECTS_DEF = 3;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        REG_TIM0   = 4'd0,
        REG_TIM1   = 4'd1,
        REG_TIM2   = 4'd2,
        REG_DESC   = 4'd3,
        REG_TIM3   = 4'd4,
        REG_SEND   = 4'd5,
        REG_GET    = 4'd6,
        REG_RSTAT  = 4'd7,
        REG_REN    = 4'd8,
        REG_RCLR   = 4'd9,
        REG_WSTAT  = 4'd10,
        REG_WEN    = 4'd11,
        REG_WCLR   = 4'd12,
        REG_INERT0 = 4'd13,
        REG_INERT1 = 4'd14,
        REG_NONE   = 4'd15
    } t_reg;

    localparam logic [31:0] DESC_KEEP_MASK = 32'h3400_0000;
    localparam logic [31:0] DESC_CS_MASK   = 32'h0003_0000;
    localparam logic [31:0] DESC_CNT_MASK  = 32'h0000_0FFF;
    localparam int          DESC_CONT_BIT  = 27;
    localparam int          DESC_SRST_BIT  = 26;
    localparam int          DESC_GET_BIT   = 25;
    localparam int          DESC_SEND_BIT  = 24;
    localparam logic [12:0] CNT_FULL       = 13'h1000;

    // Input item: op[1:0], address[9:2], write_data[41:10], miso_byte[49:42].
    localparam int IN_W  = 56;
    // Result item: read_data, access_error, mosi_valid, mosi_byte, select_line,
    // select_active, irq, tx_dma_request, rx_dma_request.
    localparam int OUT_W = 48;

endpackage

[design/smdf_fifo_mem.sv]
// ----------------------------------------------------------------------------
// smdf_fifo_mem
// Byte memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module smdf_fifo_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/spi_master_dma_fifo_controller_unit.sv]
// ----------------------------------------------------------------------------
// spi_master_dma_fifo_controller_unit
// SPI master register block with send and receive FIFOs and a queued
// descriptor; one bus access or one shifted byte per item.
// ----------------------------------------------------------------------------
// A result item appears in the cycle after its input item is accepted.
// Throughput: one item per cycle unless results stall; the FIFO memories are
// read ahead so that the head byte sits in a register and the next item sees
// the updated state. The output register accepts a new item while the result
// is taken. Reset is synchronous and active low; no clearing pass is needed.
module spi_master_dma_fifo_controller_unit
    import smdf_pkg::*;
#(
    parameter int SEND_DEPTH  = SEND_DEPTH_DEF,
    parameter int RECV_DEPTH  = RECV_DEPTH_DEF,
    parameter int NUM_SELECTS = NUM_SELECTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // operation[1:0], address[9:2], write_data[41:10], miso_byte[49:42]
    input  logic [IN_W-1:0]     s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // read_data[31:0], access_error[32], mosi_valid[33], mosi_byte[41:34],
    // select_line[43:42], select_active[44], irq[45], tx_dma_request[46],
    // rx_dma_request[47]
    output logic [OUT_W-1:0]    m_axis_tdata
);
    localparam int SAW = (SEND_DEPTH > 1) ? $clog2(SEND_DEPTH) : 1;
    localparam int RAW = (RECV_DEPTH > 1) ? $clog2(RECV_DEPTH) : 1;
    localparam int SLW = $clog2(SEND_DEPTH + 1);
    localparam int RLW = $clog2(RECV_DEPTH + 1);

    logic [1:0]  in_op;
    logic [7:0]  in_addr;
    logic [31:0] in_wd;
    logic [7:0]  in_miso;
    assign in_op   = s_axis_tdata[1:0];
    assign in_addr = s_axis_tdata[9:2];
    assign in_wd   = s_axis_tdata[41:10];
    assign in_miso = s_axis_tdata[49:42];

    logic acc;
    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign acc = s_axis_tvalid && s_axis_tready;

    // State registers.
    logic [SAW-1:0] r_srd, n_srd, r_swr, n_swr;
    logic [SLW-1:0] r_slev, n_slev;
    logic [RAW-1:0] r_rrd, n_rrd, r_rwr, n_rwr;
    logic [RLW-1:0] r_rlev, n_rlev;
    logic [31:0] r_tim [4];
    logic [31:0] r_keep, n_keep;
    logic [12:0] r_qcnt, n_qcnt;
    logic r_qs, n_qs, r_qg, n_qg, r_qc, n_qc;
    logic [1:0] r_qcs, n_qcs;
    logic [12:0] r_scnt, n_scnt, r_gcnt, n_gcnt;
    logic r_fs, n_fs, r_fg, n_fg, r_fc, n_fc;
    logic [1:0] r_cs, n_cs;
    logic r_sel, n_sel;
    logic [3:0] r_rst, n_rst, r_ren, n_ren;
    logic [4:0] r_wst, n_wst, r_wen, n_wen;
    logic [OUT_W-1:0] r_out, n_out;
    logic r_ovld;

    // Memory ports; read address is the head after this item.
    logic s_we, r_we;
    logic [7:0] s_wdata, r_wdata_b;
    logic [7:0] s_mem_q, r_mem_q;

    smdf_fifo_mem #(.DEPTH(SEND_DEPTH), .AW(SAW)) u_send (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(r_swr), .i_wdata(s_wdata),
        .i_raddr(n_srd), .o_rdata(s_mem_q)
    );
    smdf_fifo_mem #(.DEPTH(RECV_DEPTH), .AW(RAW)) u_recv (
        .i_clk(i_clk), .i_we(r_we), .i_waddr(r_rwr), .i_wdata(r_wdata_b),
        .i_raddr(n_rrd), .o_rdata(r_mem_q)
    );

    // Forwarding: a byte written to the slot being read shows up in the next cycle.
    logic r_sfw, r_rfw;
    logic [7:0] r_sfd, r_rfd;
    logic [7:0] s_head, r_head;
    assign s_head = r_sfw ? r_sfd : s_mem_q;
    assign r_head = r_rfw ? r_rfd : r_mem_q;

    function automatic logic [SAW-1:0] s_inc(input logic [SAW-1:0] p);
        return (SAW'(p) == SAW'(SEND_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction
    function automatic logic [RAW-1:0] r_inc(input logic [RAW-1:0] p);
        return (RAW'(p) == RAW'(RECV_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        logic [3:0]  off;
        logic        err;
        logic [31:0] rd;
        logic        mv;
        logic [7:0]  mo;
        logic        do_start, do_fin;
        logic        s, g;
        logic [7:0]  rx;
        n_srd = r_srd; n_swr = r_swr; n_slev = r_slev;
        n_rrd = r_rrd; n_rwr = r_rwr; n_rlev = r_rlev;
        n_keep = r_keep; n_qcnt = r_qcnt; n_qs = r_qs; n_qg = r_qg; n_qc = r_qc;
        n_qcs = r_qcs; n_scnt = r_scnt; n_gcnt = r_gcnt;
        n_fs = r_fs; n_fg = r_fg; n_fc = r_fc; n_cs = r_cs; n_sel = r_sel;
        n_rst = r_rst; n_ren = r_ren; n_wst = r_wst; n_wen = r_wen;
        s_we = 1'b0; s_wdata = in_wd[7:0]; r_we = 1'b0; r_wdata_b = 8'hFF;
        off = in_addr[5:2];
        err = 1'b0; rd = '0; mv = 1'b0; mo = 8'hFF;
        do_start = 1'b0; do_fin = 1'b0; s = 1'b0; g = 1'b0; rx = 8'hFF;
        if (acc && (in_op == OP_READ || in_op == OP_WRITE)) begin
            if (in_addr[1:0] != 2'b00 || in_addr[7:6] != 2'b00
                || off == REG_NONE) begin
                err = 1'b1;
            end else if (in_op == OP_READ) begin
                unique case (t_reg'(off))
                    REG_TIM0, REG_TIM1, REG_TIM2: rd = r_tim[off[1:0]];
                    REG_TIM3: rd = r_tim[3];
                    REG_DESC: begin
                        rd = r_keep | {19'd0, r_qcnt};
                        rd[17:16] = r_qcs;
                        rd[DESC_SEND_BIT] = r_qs;
                        rd[DESC_GET_BIT] = r_qg;
                        rd[DESC_CONT_BIT] = r_qc;
                    end
                    REG_GET: begin
                        if (r_rlev == '0) begin
                            rd = 32'h0000_00FF;
                            do_start = 1'b1;
                        end else begin
                            rd = {24'd0, r_head};
                            n_rrd = r_inc(r_rrd);
                            n_rlev = r_rlev - 1'b1;
                            do_fin = 1'b1;
                        end
                    end
                    REG_RSTAT: rd = {28'd0, r_rst};
                    REG_REN:   rd = {28'd0, r_ren};
                    REG_WSTAT: rd = {27'd0, r_wst};
                    REG_WEN:   rd = {27'd0, r_wen};
                    default:   rd = '0;
                endcase
            end else begin
                unique case (t_reg'(off))
                    REG_DESC: begin
                        n_keep = in_wd & DESC_KEEP_MASK;
                        n_qcnt = (in_wd[11:0] == 12'd0) ? CNT_FULL
                                                        : {1'b0, in_wd[11:0]};
                        n_qcs = in_wd[17:16];
                        n_qs = in_wd[DESC_SEND_BIT];
                        n_qg = in_wd[DESC_GET_BIT];
                        n_qc = in_wd[DESC_CONT_BIT];
                        if (in_wd[DESC_SRST_BIT] && (r_fs || r_fg)) begin
                            n_fs = 1'b0; n_fg = 1'b0; n_sel = 1'b0;
                            if (r_fg) n_wst[4] = 1'b1;
                        end
                        do_start = 1'b1;
                    end
                    REG_SEND: begin
                        if (r_slev < SLW'(SEND_DEPTH)) begin
                            s_we = 1'b1;
                            n_swr = s_inc(r_swr);
                            n_slev = r_slev + 1'b1;
                        end
                        n_rst[1] = 1'b1;
                        do_start = 1'b1;
                    end
                    REG_REN:  n_ren = in_wd[3:0];
                    REG_RCLR: n_rst = r_rst & ~in_wd[3:0];
                    REG_WEN:  n_wen = in_wd[4:0];
                    REG_WCLR: n_wst = r_wst & ~in_wd[4:0];
                    default: ;
                endcase
            end
        end
        // Start of a queued transfer.
        if ((do_start || (acc && in_op == OP_TICK)) && r_scnt == '0
            && r_gcnt == '0 && n_rlev == '0 && n_qcnt != '0 && (n_qs || n_qg)) begin
            if (n_cs != n_qcs && (n_fs || n_fg)) begin
                n_sel = 1'b0;
                if (n_fg) n_wst[4] = 1'b1;
            end
            n_fs = n_qs; n_fg = n_qg; n_fc = n_qc; n_cs = n_qcs;
            n_scnt = n_qs ? n_qcnt : 13'd0;
            n_gcnt = n_qg ? n_qcnt : 13'd0;
            n_qs = 1'b0; n_qg = 1'b0;
        end
        if (acc && in_op == OP_TICK && (n_fs || n_fg)
            && !(n_fg && (n_gcnt == '0 || r_rlev >= RLW'(RECV_DEPTH)))
            && !(n_fs && (n_scnt == '0 || r_slev == '0))) begin
            s = n_fs; g = n_fg;
            if (s) begin
                mo = s_head;
                n_srd = s_inc(r_srd);
                n_slev = r_slev - 1'b1;
                n_scnt = n_scnt - 1'b1;
            end
            if (32'(n_cs) < NUM_SELECTS) begin
                rx = in_miso;
                n_sel = 1'b1;
            end
            if (g) begin
                r_we = 1'b1; r_wdata_b = rx;
                n_rwr = r_inc(r_rwr);
                n_rlev = r_rlev + 1'b1;
                n_gcnt = n_gcnt - 1'b1;
                n_wst[1] = 1'b1;
            end
            mv = 1'b1;
            do_fin = 1'b1;
        end
        if (do_fin && n_scnt == '0 && n_gcnt == '0 && n_rlev == '0) begin
            s = n_fs; g = n_fg;
            if (!n_fc && (n_fs || n_fg)) begin
                n_fs = 1'b0; n_fg = 1'b0; n_sel = 1'b0;
                if (g) n_wst[4] = 1'b1;
            end
            if (s) n_rst[0] = 1'b1;
            if (g) n_wst[0] = 1'b1;
        end
        n_out = {n_fg && n_rlev != '0,
                 n_fs && n_scnt != '0 && n_slev < SLW'(SEND_DEPTH),
                 |(n_rst & n_ren) || |(n_wst & n_wen),
                 n_sel, n_cs, mo, mv, err, rd};
    end

    always_ff @(posedge i_clk) begin
        r_sfw <= s_we && (r_swr == n_srd);
        r_sfd <= s_wdata;
        r_rfw <= r_we && (r_rwr == n_rrd);
        r_rfd <= r_wdata_b;
        if (acc) r_out <= n_out;
        if (!i_rst_n) begin
            r_srd <= '0; r_swr <= '0; r_slev <= '0;
            r_rrd <= '0; r_rwr <= '0; r_rlev <= '0;
            r_tim <= '{default: '0};
            r_keep <= '0; r_qcnt <= '0; r_qs <= 1'b0; r_qg <= 1'b0; r_qc <= 1'b0;
            r_qcs <= '0; r_scnt <= '0; r_gcnt <= '0;
            r_fs <= 1'b0; r_fg <= 1'b0; r_fc <= 1'b0; r_cs <= '0; r_sel <= 1'b0;
            r_rst <= 4'h1; r_ren <= '0; r_wst <= 5'h11; r_wen <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_srd <= n_srd; r_swr <= n_swr; r_slev <= n_slev;
            r_rrd <= n_rrd; r_rwr <= n_rwr; r_rlev <= n_rlev;
            if (acc && in_op == OP_WRITE && in_addr[1:0] == 2'b00
                && in_addr[7:6] == 2'b00) begin
                if (in_addr[5:2] == REG_TIM0) r_tim[0] <= in_wd;
                if (in_addr[5:2] == REG_TIM1) r_tim[1] <= in_wd;
                if (in_addr[5:2] == REG_TIM2) r_tim[2] <= in_wd;
                if (in_addr[5:2] == REG_TIM3) r_tim[3] <= in_wd;
            end
            r_keep <= n_keep; r_qcnt <= n_qcnt; r_qs <= n_qs; r_qg <= n_qg;
            r_qc <= n_qc; r_qcs <= n_qcs; r_scnt <= n_scnt; r_gcnt <= n_gcnt;
            r_fs <= n_fs; r_fg <= n_fg; r_fc <= n_fc; r_cs <= n_cs; r_sel <= n_sel;
            r_rst <= n_rst; r_ren <= n_ren; r_wst <= n_wst; r_wen <= n_wen;
            if (acc) r_ovld <= 1'b1;
            else if (m_axis_tready) r_ovld <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_out;
endmodule

[design/smdf_checker.sv]
// ----------------------------------------------------------------------------
// smdf_checker
// Port-level checks of the SPI master block, bound to the top level.
// ----------------------------------------------------------------------------
module smdf_checker
    import smdf_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("no result after an accepted item");
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output empty");
    a_no_mosi_on_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] != OP_TICK
        |=> !m_axis_tdata[33])
        else $error("byte shifted on a register access");
    a_idle_mosi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[33] |-> m_axis_tdata[41:34] == 8'hFF)
        else $error("mosi byte not idle");
endmodule

bind spi_master_dma_fifo_controller_unit smdf_checker u_smdf_checker (.*);

[sim/tb_spi_master_dma_fifo_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_master_dma_fifo_controller_unit
// Drives bus reads, bus writes and shift ticks into the SPI master and checks
// every result item against a cycle-free predictor of the registers, FIFOs,
// descriptor and interrupt logic, under random idling on both streams.
// ----------------------------------------------------------------------------
module tb_spi_master_dma_fifo_controller_unit;
    import smdf_pkg::*;

    localparam int SDEP = 32;
    localparam int RDEP = 32;
    localparam int NSEL = 3;

    typedef struct packed {
        logic        rxreq;
        logic        txreq;
        logic        irq;
        logic        csact;
        logic [1:0]  cs;
        logic [7:0]  mbyte;
        logic        mvalid;
        logic        err;
        logic [31:0] rdata;
    } t_res;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [IN_W-1:0]    s_axis_tdata;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;

    spi_master_dma_fifo_controller_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        i_clk = 1'b1; #6;
        i_clk = 1'b0; #6;
    end

    // Predictor state.
    logic [7:0]  sfifo [SDEP];
    logic [7:0]  rfifo [RDEP];
    int unsigned s_rd, s_wr, s_lvl, r_rd, r_wr, r_lvl;
    logic [31:0] timing [4];
    logic [31:0] kept_bits;
    logic [12:0] q_cnt;
    logic        q_send, q_get, q_cont;
    logic [1:0]  q_cs;
    int unsigned send_left, get_left;
    logic        a_send, a_get, a_cont;
    logic [1:0]  a_cs;
    logic        cs_on;
    logic [3:0]  rstat, ren;
    logic [4:0]  wstat, wen;

    logic [IN_W-1:0] pending_items[$];
    t_res            expected_results[$];
    int              n_errors;
    int              hold_gap;
    int              stall_gap;
    bit              stim_done;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
        n_errors++;
    endtask

    function automatic bit is_idle();
        return send_left == 0 && get_left == 0 && r_lvl == 0;
    endfunction

    function automatic void end_xfer();
        if (!(a_send || a_get)) return;
        if (a_get) wstat[4] = 1'b1;
        a_send = 0;
        a_get = 0;
        cs_on = 0;
    endfunction

    function automatic void try_start();
        if (!is_idle() || q_cnt == 0 || !(q_send || q_get)) return;
        if (a_cs != q_cs) end_xfer();
        a_send = q_send;
        a_get = q_get;
        a_cont = q_cont;
        a_cs = q_cs;
        send_left = q_send ? q_cnt : 0;
        get_left = q_get ? q_cnt : 0;
        q_send = 0;
        q_get = 0;
    endfunction

    function automatic void finish_xfer();
        logic s, g;
        s = a_send;
        g = a_get;
        if (!a_cont) end_xfer();
        if (s) rstat[0] = 1'b1;
        if (g) wstat[0] = 1'b1;
    endfunction

    function automatic t_res predict_spi(input logic [IN_W-1:0] item);
        t_res r;
        t_op op;
        logic [7:0] addr, miso, rx;
        logic [31:0] wd;
        logic [3:0] off;
        op = t_op'(item[1:0]);
        addr = item[9:2];
        wd = item[41:10];
        miso = item[49:42];
        off = addr[5:2];
        r = '0;
        r.mbyte = 8'hff;
        if (op == OP_READ || op == OP_WRITE) begin
            if (addr[1:0] != 0 || addr[7:2] > 14) begin
                r.err = 1'b1;
            end else if (op == OP_READ) begin
                case (t_reg'(off))
                    REG_TIM0, REG_TIM1, REG_TIM2: r.rdata = timing[off[1:0]];
                    REG_TIM3: r.rdata = timing[3];
                    REG_DESC: r.rdata = kept_bits | 32'(q_cnt) | (32'(q_cs) << 16)
                        | (32'(q_send) << DESC_SEND_BIT) | (32'(q_get) << DESC_GET_BIT)
                        | (32'(q_cont) << DESC_CONT_BIT);
                    REG_GET: begin
                        if (r_lvl == 0) begin
                            try_start();
                            r.rdata = 32'hff;
                        end else begin
                            r.rdata = 32'(rfifo[r_rd]);
                            r_rd = (r_rd + 1) % RDEP;
                            r_lvl--;
                            if (is_idle()) finish_xfer();
                        end
                    end
                    REG_RSTAT: r.rdata = 32'(rstat);
                    REG_REN: r.rdata = 32'(ren);
                    REG_WSTAT: r.rdata = 32'(wstat);
                    REG_WEN: r.rdata = 32'(wen);
                    default: r.rdata = 0;
                endcase
            end else begin
                case (t_reg'(off))
                    REG_TIM0, REG_TIM1, REG_TIM2: timing[off[1:0]] = wd;
                    REG_TIM3: timing[3] = wd;
                    REG_DESC: begin
                        kept_bits = wd & DESC_KEEP_MASK;
                        q_cnt = (wd[11:0] == 0) ? CNT_FULL : {1'b0, wd[11:0]};
                        q_cs = wd[17:16];
                        q_send = wd[DESC_SEND_BIT];
                        q_get = wd[DESC_GET_BIT];
                        q_cont = wd[DESC_CONT_BIT];
                        if (wd[DESC_SRST_BIT]) end_xfer();
                        try_start();
                    end
                    REG_SEND: begin
                        if (s_lvl < SDEP) begin
                            sfifo[s_wr] = wd[7:0];
                            s_wr = (s_wr + 1) % SDEP;
                            s_lvl++;
                        end
                        rstat[1] = 1'b1;
                        try_start();
                    end
                    REG_REN: ren = wd[3:0];
                    REG_RCLR: rstat = rstat & ~wd[3:0];
                    REG_WEN: wen = wd[4:0];
                    REG_WCLR: wstat = wstat & ~wd[4:0];
                    default: ;
                endcase
            end
        end else if (op == OP_TICK) begin
            try_start();
            if ((a_send || a_get)
                && !(a_get && (get_left == 0 || r_lvl >= RDEP))
                && !(a_send && (send_left == 0 || s_lvl == 0))) begin
                if (a_send) begin
                    r.mbyte = sfifo[s_rd];
                    s_rd = (s_rd + 1) % SDEP;
                    s_lvl--;
                    send_left--;
                end
                rx = 8'hff;
                if (a_cs < NSEL) begin
                    rx = miso;
                    cs_on = 1'b1;
                end
                if (a_get) begin
                    rfifo[r_wr] = rx;
                    r_wr = (r_wr + 1) % RDEP;
                    r_lvl++;
                    get_left--;
                    wstat[1] = 1'b1;
                end
                r.mvalid = 1'b1;
                if (is_idle()) finish_xfer();
            end
        end
        r.cs = a_cs;
        r.csact = cs_on;
        r.irq = |(rstat & ren) || |(wstat & wen);
        r.txreq = a_send && send_left != 0 && s_lvl < SDEP;
        r.rxreq = a_get && r_lvl != 0;
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_item(t_op op, logic [7:0] addr,
                                                  logic [31:0] wd, logic [7:0] miso);
        logic [IN_W-1:0] v;
        v = '0;
        v[1:0] = op;
        v[9:2] = addr;
        v[41:10] = wd;
        v[49:42] = miso;
        return v;
    endfunction

    function automatic logic [7:0] reg_addr(t_reg r);
        return {2'b00, r[3:0], 2'b00};
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 40) return 0;
        if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            hold_gap <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                void'(pending_items.pop_front());
            end
            if (hold_gap > 0) begin
                hold_gap <= hold_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_axis_tdata <= pending_items[0];
                s_axis_tvalid <= 1'b1;
                hold_gap <= pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Prediction on acceptance; checking on results.
    always @(posedge i_clk) begin
        t_res got, exp;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_results.push_back(predict_spi(s_axis_tdata));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_res'(m_axis_tdata);
            if (expected_results.size() == 0) begin
                report("unexpected item", got.rdata, 0);
            end else begin
                exp = expected_results.pop_front();
                if (got.rdata !== exp.rdata) report("read_data", got.rdata, exp.rdata);
                if (got.err !== exp.err) report("access_error", got.err, exp.err);
                if (got.mvalid !== exp.mvalid) report("mosi_valid", got.mvalid, exp.mvalid);
                if (got.mbyte !== exp.mbyte) report("mosi_byte", got.mbyte, exp.mbyte);
                if (got.cs !== exp.cs) report("select_line", got.cs, exp.cs);
                if (got.csact !== exp.csact) report("select_active", got.csact, exp.csact);
                if (got.irq !== exp.irq) report("irq", got.irq, exp.irq);
                if (got.txreq !== exp.txreq) report("tx_dma_request", got.txreq, exp.txreq);
                if (got.rxreq !== exp.rxreq) report("rx_dma_request", got.rxreq, exp.rxreq);
            end
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_gap <= 0;
        end else if (stall_gap > 0) begin
            stall_gap <= stall_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_gap <= ($urandom_range(0, 99) < 30) ? pick_gap() : 0;
        end
    end

    task automatic add(t_op op, logic [7:0] addr, logic [31:0] wd, logic [7:0] miso);
        pending_items.push_back(pack_item(op, addr, wd, miso));
    endtask

    function automatic logic [31:0] rand_desc();
        logic [31:0] d;
        d = $urandom();
        d[11:0] = ($urandom_range(0, 19) == 0) ? d[11:0] : 12'($urandom_range(1, 40));
        if ($urandom_range(0, 7) != 0) d[DESC_SRST_BIT] = 1'b0;
        return d;
    endfunction

    initial begin
        int k, n;
        t_op op;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        n_errors = 0;
        stim_done = 0;
        s_rd = 0; s_wr = 0; s_lvl = 0; r_rd = 0; r_wr = 0; r_lvl = 0;
        for (int i = 0; i < 4; i++) timing[i] = 0;
        kept_bits = 0; q_cnt = 0; q_send = 0; q_get = 0; q_cont = 0; q_cs = 0;
        send_left = 0; get_left = 0; a_send = 0; a_get = 0; a_cont = 0; a_cs = 0;
        cs_on = 0; rstat = 4'h1; ren = 0; wstat = 5'h11; wen = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add(OP_READ, reg_addr(REG_RSTAT), 0, 0);
        add(OP_READ, reg_addr(REG_WSTAT), 0, 0);
        add(OP_WRITE, reg_addr(REG_TIM0), 32'hffff_ffff, 0);
        add(OP_WRITE, reg_addr(REG_TIM3), 32'h0, 0);
        add(OP_READ, reg_addr(REG_TIM0), 0, 0);
        add(OP_READ, 8'h02, 0, 0);
        add(OP_WRITE, 8'hfc, 32'hffff_ffff, 0);
        add(OP_NONE, 8'hff, 32'hffff_ffff, 8'hff);
        add(OP_WRITE, reg_addr(REG_REN), 32'hf, 0);
        add(OP_WRITE, reg_addr(REG_WEN), 32'h1f, 0);
        add(OP_READ, reg_addr(REG_GET), 0, 0);
        for (int i = 0; i < 34; i++)
            add(OP_WRITE, reg_addr(REG_SEND), $urandom(), 0);
        add(OP_WRITE, reg_addr(REG_DESC), 32'h0b00_0000 | 32'd3, 0);
        add(OP_TICK, 0, 0, 8'h00);
        add(OP_TICK, 0, 0, 8'hff);
        add(OP_TICK, 0, 0, 8'h5a);
        add(OP_READ, reg_addr(REG_GET), 0, 0);
        add(OP_READ, reg_addr(REG_DESC), 0, 0);
        add(OP_WRITE, reg_addr(REG_DESC), 32'h3603_0000, 0);
        add(OP_TICK, 0, 0, 8'h11);
        add(OP_WRITE, reg_addr(REG_RCLR), 32'hffff_ffff, 0);
        add(OP_WRITE, reg_addr(REG_WCLR), 32'hffff_ffff, 0);
        add(OP_READ, reg_addr(REG_INERT1), 0, 0);

        // Pause until every result is back.
        wait (pending_items.size() == 0 && expected_results.size() == 0);
        repeat (4) @(posedge i_clk);

        n = 0;
        while (n < 1000) begin
            k = $urandom_range(0, 99);
            if (k < 10) begin
                add(OP_WRITE, reg_addr(REG_DESC), rand_desc(), 8'($urandom()));
            end else if (k < 30) begin
                add(OP_WRITE, reg_addr(REG_SEND), $urandom(), 8'($urandom()));
            end else if (k < 65) begin
                add(OP_TICK, 8'($urandom()), $urandom(), 8'($urandom()));
            end else if (k < 78) begin
                add(OP_READ, reg_addr(REG_GET), $urandom(), 8'($urandom()));
            end else if (k < 92) begin
                op = t_op'($urandom_range(0, 1));
                add(op, {2'b00, 4'($urandom_range(0, 14)), 2'b00},
                    ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 31),
                    8'($urandom()));
            end else begin
                add(t_op'($urandom_range(0, 3)), 8'($urandom()), $urandom(),
                    8'($urandom()));
            end
            n++;
        end
        wait (pending_items.size() == 0 && !s_axis_tvalid);
        wait (expected_results.size() == 0);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("tb_spi_master_dma_fifo_controller_unit: clean");
        end else begin
            $display("tb_spi_master_dma_fifo_controller_unit: errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb_spi_master_dma_fifo_controller_unit: errors");
        $finish;
    end

endmodule

[spi_master_dma_fifo_controller_unit.f]
design/smdf_pkg.sv
design/smdf_fifo_mem.sv
design/spi_master_dma_fifo_controller_unit.sv
design/smdf_checker.sv
sim/tb_spi_master_dma_fifo_controller_unit.sv
